// ===== rtl/ssr_pkg.sv =====
// Shared types and constants of the silhouette row scorer.
package ssr_pkg;
   localparam int FRAC_BITS = 16;
   localparam int QW = FRAC_BITS + 1;
   typedef logic [QW-1:0] frac_type;
   typedef logic signed [15:0] q15_type;
   localparam frac_type FRAC_ONE = frac_type'(1) << FRAC_BITS;
   localparam q15_type Q15_MAX = 16'sh7fff;
endpackage

// ===== rtl/ssr_bins.sv =====
// Per-cluster sum and count memory, one write port, one registered read port.
module ssr_bins #(
   parameter int DEPTH = 16,
   parameter int AW = 4,
   parameter int DW = 57
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/ssr_div.sv =====
// Restoring fraction divider: floor(num/den * 2^16), one quotient bit a cycle.
module ssr_div #(
   parameter int W = 57
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [W-1:0]    num,
   input  logic [W-1:0]    den,
   output logic            done,
   output ssr_pkg::frac_type quo
);
   logic [W-1:0] rem_ff, rem_in, den_ff;
   ssr_pkg::frac_type quo_ff, quo_in;
   logic [4:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   logic [W:0] twice;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      twice   = {rem_ff, 1'b0};
      if (start) begin
         if (num >= den) begin
            quo_in  = ssr_pkg::FRAC_ONE;
            cnt_in  = 5'd0;
            done_in = 1'b1;
         end else begin
            rem_in = num;
            quo_in = '0;
            cnt_in = 5'(ssr_pkg::FRAC_BITS);
         end
      end else if (cnt_ff != 5'd0) begin
         if (twice >= {1'b0, den_ff}) begin
            rem_in = W'(twice - {1'b0, den_ff});
            quo_in = {quo_ff[ssr_pkg::QW-2:0], 1'b1};
         end else begin
            rem_in = W'(twice);
            quo_in = {quo_ff[ssr_pkg::QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

// ===== rtl/silhouette_score_rows_top.sv =====
// Silhouette row scorer: top level with bin memory, row-end scan and divider.
// A word that does not end a row is read at accept (ST_IDLE) and its bin is
// written back in ST_UPD under req_stall, so no new word is taken before that.
// A row end then runs the bin scan (ST_SRD, ST_SMUL, ST_SCMP per cluster),
// scaling (ST_FMUL, ST_FSUB), the divider launch (ST_DGO), the divide (ST_DIV,
// one quotient bit a cycle) and the result load (ST_OUT). Reset: synchronous;
// after it a clearing pass (ST_CLR) over all MAX_CLUSTERS bins zeroes the bin memory while req_stall stays high.
module silhouette_score_rows_top #(
   parameter int MAX_CLUSTERS = 16,
   parameter int MAX_POINTS   = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [31:0]          req_distance,
   input  logic [3:0]           req_col_cluster,
   input  logic                 req_is_self,
   input  logic                 req_last_in_row,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ssr_pkg::q15_type     rsp_silhouette,
   output logic                 rsp_singleton,
   output logic                 rsp_no_neighbour
);
   // Bin geometry: sums hold MAX_POINTS distances, counts reach MAX_POINTS.
   localparam int AW = $clog2(MAX_CLUSTERS);
   localparam int SW = 32 + $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int PW = SW + CW;
   localparam int DW = SW + CW;

   typedef enum logic [3:0] {
      ST_CLR, ST_IDLE, ST_UPD, ST_SRD, ST_SMUL, ST_SCMP,
      ST_FMUL, ST_FSUB, ST_DGO, ST_DIV, ST_OUT
   } state_type;

   state_type state_ff;
   logic [AW-1:0] k_ff;

   // Word held across the read-modify-write.
   logic [31:0]   dist_ff;
   logic [AW-1:0] addr_ff;
   logic          use_ff, last_ff;

   // Row state.
   logic [3:0]    own_ff;
   logic          own_seen_ff;
   logic          own_hit;

   // Scan state.
   logic [SW-1:0] sa_ff, sb_ff, cur_sum_ff;
   logic [CW-1:0] na_ff, nb_ff, cur_cnt_ff;
   logic          have_b_ff;
   logic [PW-1:0] pa_ff, pb_ff;
   logic [PW-1:0] x_ff, y_ff;
   logic          neg_ff;
   logic [PW-1:0] num_ff, den_ff;

   // Result register.
   logic              rsp_valid_ff;
   ssr_pkg::q15_type  sil_ff;
   logic              single_ff, nonb_ff;
   ssr_pkg::q15_type  res_ff;
   logic              rsp_sing_ff, rsp_nonb_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [DW-1:0] mem_wdata, mem_rdata;
   logic [SW-1:0] rd_sum;
   logic [CW-1:0] rd_cnt;

   logic          div_start, div_done;
   ssr_pkg::frac_type div_quo;
   logic [ssr_pkg::QW-1:0] mag;

   logic accept, out_free, in_range;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign in_range = int'(req_col_cluster) < MAX_CLUSTERS;
   assign own_hit  = own_seen_ff && (int'(own_ff) < MAX_CLUSTERS)
                     && (AW'(own_ff) == k_ff);
   assign rd_sum   = mem_rdata[DW-1:CW];
   assign rd_cnt   = mem_rdata[CW-1:0];

   // Read the word's bin straight off the port at accept; otherwise the scan slot.
   assign mem_raddr = (state_ff == ST_IDLE) ? AW'(req_col_cluster) : k_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = k_ff;
      mem_wdata = '0;
      case (state_ff)
         ST_CLR:  mem_we = 1'b1;
         ST_SCMP: mem_we = 1'b1;
         ST_UPD: begin
            mem_waddr = addr_ff;
            mem_wdata = {rd_sum + SW'(dist_ff), rd_cnt + CW'(1)};
            mem_we    = use_ff && (int'(rd_cnt) < MAX_POINTS);
         end
         default: mem_we = 1'b0;
      endcase
   end

   ssr_bins #(.DEPTH(MAX_CLUSTERS), .AW(AW), .DW(DW)) u_bins (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Launch the divider once num/den are settled in their registers.
   assign div_start = (state_ff == ST_DGO) && (den_ff != '0);

   ssr_div #(.W(PW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Round half up on the 16-bit fraction to get a Q1.15 magnitude.
   assign mag = (div_quo + ssr_pkg::QW'(1)) >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         k_ff         <= '0;
         own_seen_ff  <= 1'b0;
         own_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLR: begin
               if (k_ff == AW'(MAX_CLUSTERS - 1)) begin
                  k_ff     <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  k_ff <= k_ff + AW'(1);
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  dist_ff  <= req_distance;
                  addr_ff  <= AW'(req_col_cluster);
                  use_ff   <= !req_is_self && in_range;
                  last_ff  <= req_last_in_row;
                  if (req_is_self) begin
                     own_ff      <= req_col_cluster;
                     own_seen_ff <= 1'b1;
                  end
                  state_ff <= ST_UPD;
               end
            end
            ST_UPD: begin
               // Write back the bin; a row end starts the scan.
               k_ff      <= '0;
               have_b_ff <= 1'b0;
               sa_ff     <= '0;
               na_ff     <= '0;
               sb_ff     <= '0;
               nb_ff     <= '0;
               state_ff  <= last_ff ? ST_SRD : ST_IDLE;
            end
            ST_SRD: state_ff <= ST_SMUL;
            ST_SMUL: begin
               // Cross-multiply means against the best so far.
               cur_sum_ff <= rd_sum;
               cur_cnt_ff <= rd_cnt;
               pa_ff      <= PW'(rd_sum) * PW'(nb_ff);
               pb_ff      <= PW'(sb_ff) * PW'(rd_cnt);
               state_ff   <= ST_SCMP;
            end
            ST_SCMP: begin
               if (own_hit) begin
                  sa_ff <= cur_sum_ff;
                  na_ff <= cur_cnt_ff;
               end else if (cur_cnt_ff != '0 && (!have_b_ff || pa_ff < pb_ff)) begin
                  sb_ff     <= cur_sum_ff;
                  nb_ff     <= cur_cnt_ff;
                  have_b_ff <= 1'b1;
               end
               if (k_ff == AW'(MAX_CLUSTERS - 1)) begin
                  k_ff     <= '0;
                  state_ff <= ST_FMUL;
               end else begin
                  k_ff     <= k_ff + AW'(1);
                  state_ff <= ST_SRD;
               end
            end
            ST_FMUL: begin
               x_ff      <= PW'(sa_ff) * PW'(nb_ff);
               y_ff      <= PW'(sb_ff) * PW'(na_ff);
               single_ff <= (na_ff == '0);
               nonb_ff   <= !have_b_ff;
               res_ff    <= '0;
               state_ff  <= (na_ff == '0 || !have_b_ff) ? ST_OUT : ST_FSUB;
            end
            ST_FSUB: begin
               if (y_ff >= x_ff) begin
                  num_ff <= y_ff - x_ff;
                  den_ff <= y_ff;
                  neg_ff <= 1'b0;
               end else begin
                  num_ff <= x_ff - y_ff;
                  den_ff <= x_ff;
                  neg_ff <= 1'b1;
               end
               state_ff <= ST_DGO;
            end
            ST_DGO: begin
               // Zero denominator: no divide is started, result stays zero.
               state_ff <= (den_ff == '0) ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  if (neg_ff) begin
                     res_ff <= ssr_pkg::q15_type'(ssr_pkg::FRAC_ONE - mag);
                  end else if (mag > ssr_pkg::QW'(ssr_pkg::Q15_MAX)) begin
                     res_ff <= ssr_pkg::Q15_MAX;
                  end else begin
                     res_ff <= ssr_pkg::q15_type'(mag);
                  end
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               // Hold until the result register is free, then drop row state.
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  sil_ff       <= res_ff;
                  own_seen_ff  <= 1'b0;
                  own_ff       <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // FSUB registers num/den, and the divider sees them in the cycle after, in ST_DGO.
   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_silhouette   = sil_ff;
   assign rsp_singleton    = rsp_sing_ff;
   assign rsp_no_neighbour = rsp_nonb_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_sing_ff <= single_ff;
         rsp_nonb_ff <= nonb_ff;
      end
   end
endmodule

// ===== rtl/ssr_checker.sv =====
// Port-level checks for the silhouette row scorer, bound to the top level.
module ssr_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input ssr_pkg::q15_type     rsp_silhouette,
   input logic                 rsp_singleton,
   input logic                 rsp_no_neighbour
);
   // Each accepted word needs its write-back cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken on back-to-back cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_silhouette))
      else $error("stalled result word changed");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_singleton || rsp_no_neighbour) |-> rsp_silhouette == '0)
      else $error("flagged result not zero");
endmodule

bind silhouette_score_rows_top ssr_checker u_ssr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_silhouette   (rsp_silhouette),
   .rsp_singleton    (rsp_singleton),
   .rsp_no_neighbour (rsp_no_neighbour)
);

// ===== tb/silhouette_score_rows_top_test.sv =====
// Self-checking testbench for the silhouette row scorer.
module silhouette_score_rows_top_test;

   localparam int NCLUST = 16;
   localparam int NPTS   = 4096;

   typedef struct packed {
      logic signed [15:0] silhouette;
      logic               singleton;
      logic               no_neighbour;
   } score_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_distance;
   logic [3:0]  req_col_cluster;
   logic        req_is_self;
   logic        req_last_in_row;
   logic        rsp_valid;
   logic        rsp_stall;
   ssr_pkg::q15_type rsp_silhouette;
   logic        rsp_singleton;
   logic        rsp_no_neighbour;

   silhouette_score_rows_top i_dut (.*);

   // Predictor state: one row of bins, mirrored from the block's behavior.
   logic [43:0] bin_sum [NCLUST];
   logic [12:0] bin_cnt [NCLUST];
   logic [3:0]  self_idx;
   logic        self_seen;

   score_type expected_scores[$];
   int     errors = 0;
   bit     sending_done = 0;
   int     stall_mode = 0;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Clear the row bins after each row end.
   task automatic clear_bins();
      for (int k = 0; k < NCLUST; k++) begin
         bin_sum[k] = '0;
         bin_cnt[k] = '0;
      end
      self_idx  = '0;
      self_seen = 1'b0;
   endtask

   // Fold one word into the bins; on a row end, compute the expected score.
   task automatic predict_score(input logic [31:0] dist_w, input logic [3:0] cl,
                                input logic self_f, input logic last_f);
      logic [63:0] sa, na, sb, nb, x, y, num, den, r;
      logic        have_b, neg;
      logic [16:0] q;
      logic [16:0] mag;
      score_type   s;
      sa = 0; na = 0; sb = 0; nb = 0; have_b = 0;
      if (self_f) begin
         self_idx  = cl;
         self_seen = 1'b1;
      end else if (bin_cnt[cl] < NPTS) begin
         bin_sum[cl] += dist_w;
         bin_cnt[cl] += 1;
      end
      if (!last_f) return;
      if (self_seen) begin
         sa = bin_sum[self_idx];
         na = bin_cnt[self_idx];
      end
      for (int k = 0; k < NCLUST; k++) begin
         if (self_seen && k == self_idx) continue;
         if (bin_cnt[k] == 0) continue;
         // keep the smallest mean, compared by cross products
         if (!have_b || 64'(bin_sum[k]) * nb < sb * 64'(bin_cnt[k])) begin
            sb = bin_sum[k];
            nb = bin_cnt[k];
            have_b = 1;
         end
      end
      s.silhouette   = '0;
      s.singleton    = (na == 0);
      s.no_neighbour = !have_b;
      clear_bins();
      if (na != 0 && have_b) begin
         x = sa * nb;
         y = sb * na;
         if (y >= x) begin
            num = y - x; den = y; neg = 0;
         end else begin
            num = x - y; den = x; neg = 1;
         end
         if (den != 0) begin
            if (num >= den) q = 17'h10000;
            else begin
               r = num; q = 0;
               for (int i = 0; i < 16; i++) begin
                  q = q << 1;
                  if (r >= den - r) begin
                     r = r - (den - r);
                     q[0] = 1'b1;
                  end else r = r + r;
               end
            end
            mag = (q + 1) >> 1;
            if (neg) s.silhouette = 16'(17'h10000 - mag);
            else s.silhouette = (mag > 32767) ? 16'sh7fff : 16'(mag);
         end
      end
      expected_scores.push_back(s);
   endtask

   // Send one word: idle at random between bursts, hold the word until accepted.
   int burst_left = 0;
   task automatic send_word(input logic [31:0] dist_w, input logic [3:0] cl,
                            input logic self_f, input logic last_f);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_valid       <= 1'b1;
      req_distance    <= dist_w;
      req_col_cluster <= cl;
      req_is_self     <= self_f;
      req_last_in_row <= last_f;
      predict_score(dist_w, cl, self_f, last_f);
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      burst_left--;
   endtask

   // Random row: self item somewhere, column clusters from the first nclu indices.
   task automatic send_row(input int npts, input int nclu, input int dist_mode);
      int self_pos;
      logic [31:0] d;
      self_pos = $urandom_range(0, npts - 1);
      for (int i = 0; i < npts; i++) begin
         case (dist_mode)
            0: d = $urandom;
            1: d = $urandom_range(0, 32'h0004_0000);
            default: d = $urandom_range(0, 3);
         endcase
         send_word(d, 4'($urandom_range(0, nclu - 1)), i == self_pos, i == npts - 1);
      end
   endtask

   // Drop valid, wait for every expected score, then the block's row-end latency.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_scores.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic test_directed();
      // extremes of distance and of cluster index, both flags
      send_word(32'hffff_ffff, 4'd0, 1'b1, 1'b0);
      send_word(32'hffff_ffff, 4'd0, 1'b0, 1'b0);
      send_word(32'h0000_0000, 4'd15, 1'b0, 1'b1);
      // singleton: own cluster has no other member
      send_word(32'h0001_0000, 4'd3, 1'b1, 1'b0);
      send_word(32'h0002_0000, 4'd5, 1'b0, 1'b1);
      // no neighbour only
      send_word(32'h0001_0000, 4'd7, 1'b1, 1'b0);
      send_word(32'h0003_0000, 4'd7, 1'b0, 1'b1);
      // singleton and no neighbour together: lone self item
      send_word(32'h0000_1234, 4'd9, 1'b1, 1'b1);
      // zero denominator
      send_word(32'h0, 4'd1, 1'b1, 1'b0);
      send_word(32'h0, 4'd1, 1'b0, 1'b0);
      send_word(32'h0, 4'd2, 1'b0, 1'b1);
      // missing self item
      send_word(32'h0005_0000, 4'd4, 1'b0, 1'b0);
      send_word(32'h0006_0000, 4'd6, 1'b0, 1'b1);
      // several self items: the last names the own cluster
      send_word(32'h0000_0000, 4'd10, 1'b1, 1'b0);
      send_word(32'h0000_0000, 4'd11, 1'b0, 1'b0);
      send_word(32'h0000_0000, 4'd11, 1'b1, 1'b0);
      send_word(32'h0009_0000, 4'd12, 1'b0, 1'b0);
      send_word(32'h0000_0000, 4'd10, 1'b0, 1'b1);
      // negative extreme: own mean far above the neighbour's
      send_word(32'h8000_0000, 4'd14, 1'b0, 1'b0);
      send_word(32'h0000_0001, 4'd13, 1'b0, 1'b0);
      send_word(32'h0000_0000, 4'd14, 1'b1, 1'b1);
      drain();
   endtask

   task automatic test_random_rows();
      int sent;
      sent = 0;
      while (sent < 1480) begin
         int n, nc, stage;
         stage = $urandom_range(0, 9);
         n  = (stage == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
         nc = (stage < 3) ? $urandom_range(1, 3) : $urandom_range(2, 16);
         stall_mode = $urandom_range(0, 3);
         send_row(n, nc, $urandom_range(0, 2));
         sent += n;
      end
      drain();
   endtask

   // Receiver: stall on its own pattern; mode 0 never stalls.
   int stall_phase = 0;
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else begin
         stall_phase <= stall_phase + 1;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= (stall_phase % 7) < 3;
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   // Check each accepted result word against the oldest expected score.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_scores.size() == 0) begin
            $display("%0t: result word with nothing expected: sil=%0d sgl=%0b nn=%0b",
                     $time, rsp_silhouette, rsp_singleton, rsp_no_neighbour);
            errors++;
         end else begin
            score_type e;
            e = expected_scores.pop_front();
            if (rsp_silhouette !== e.silhouette) begin
               $display("%0t: silhouette expected %0d actual %0d", $time,
                        e.silhouette, rsp_silhouette);
               errors++;
            end
            if (rsp_singleton !== e.singleton) begin
               $display("%0t: singleton expected %0b actual %0b", $time,
                        e.singleton, rsp_singleton);
               errors++;
            end
            if (rsp_no_neighbour !== e.no_neighbour) begin
               $display("%0t: no_neighbour expected %0b actual %0b", $time,
                        e.no_neighbour, rsp_no_neighbour);
               errors++;
            end
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_distance    = '0;
      req_col_cluster = '0;
      req_is_self     = 1'b0;
      req_last_in_row = 1'b0;
      rsp_stall       = 1'b0;
      clear_bins();
      repeat (6) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_rows();
      if (errors == 0 && expected_scores.size() == 0)
         $display("** silhouette_score_rows_top: PASSED **");
      else
         $display("** silhouette_score_rows_top: FAILED **");
      $finish;
   end

   // Generous limit on the whole run.
   initial begin
      #5_000_000;
      $display("** silhouette_score_rows_top: FAILED **");
      $finish;
   end
endmodule
